>>> design/ipsf_pkg.sv
// Package for the IP source allow/deny filter.
// Holds commands, reason codes, ethertypes, table word types and the FSM type.
`default_nettype none
package ipsf_pkg;
    localparam int ALLOW_ENTRIES_DEF = 64;
    localparam int DENY_ENTRIES_DEF  = 64;
    localparam int MAX_VLAN_TAGS_DEF = 2;

    localparam logic [15:0] TYPE_QTAG  = 16'h8100;
    localparam logic [15:0] TYPE_ADTAG = 16'h88a8;
    localparam logic [15:0] TYPE_IPV4  = 16'h0800;
    localparam logic [15:0] TYPE_IPV6  = 16'h86DD;
    localparam logic [6:0]  COUNT_MAX  = 7'd127;

    typedef enum logic [1:0] {
        CMD_BYTE  = 2'd0,
        CMD_ALLOW = 2'd1,
        CMD_DENY  = 2'd2,
        CMD_NONE  = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        RSN_OTHER   = 3'd0,
        RSN_MALF    = 3'd1,
        RSN_CLEAN   = 3'd2,
        RSN_NOTALLW = 3'd3,
        RSN_DENIED  = 3'd4
    } reason_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_TAIL
    } state_t;

    typedef struct packed {
        logic        needs_scan;
        logic        is_v6;
        reason_t     reason;
        logic [63:0] key_hi;
        logic [63:0] key_lo;
    } frame_info_t;

    typedef struct packed {
        logic [63:0] hi;
        logic [63:0] lo;
        logic [7:0]  prefix;
        logic        v6;
    } allow_word_t;

    typedef struct packed {
        logic [63:0] hi;
        logic [63:0] lo;
        logic        v6;
    } deny_word_t;
endpackage
`default_nettype wire

>>> design/ipsf_parser.sv
// Frame header parser: tags, ethertype, IP header checks, source capture.
// Depends on ipsf_pkg.
`default_nettype none
module ipsf_parser #(
    parameter int MAX_VLAN_TAGS = ipsf_pkg::MAX_VLAN_TAGS_DEF
) (
    input  wire                     aclk,
    input  wire                     aresetn,
    input  wire                     byte_en,
    input  wire [7:0]               byte_in,
    input  wire                     byte_last,
    output ipsf_pkg::frame_info_t   info
);
    import ipsf_pkg::*;

    logic [6:0]  cnt_reg, cnt_next;
    logic [15:0] et_reg, et_next;
    logic [4:0]  off_reg, off_next;
    logic [3:0]  ver_reg, ver_next;
    logic [3:0]  ihl_reg, ihl_next;
    logic [63:0] shi_reg, shi_next;
    logic [63:0] slo_reg, slo_next;
    logic [7:0]  p, off8, len, offn;

    always_comb begin
        p    = {1'b0, cnt_reg};
        off8 = {3'b0, off_reg};
        cnt_next = (cnt_reg < COUNT_MAX) ? cnt_reg + 7'd1 : COUNT_MAX;
        et_next  = et_reg;
        off_next = off_reg;
        ver_next = ver_reg;
        ihl_next = ihl_reg;
        shi_next = shi_reg;
        slo_next = slo_reg;
        if (p == off8 - 8'd2) begin
            et_next = {byte_in, 8'h00};
        end else if (p == off8 - 8'd1) begin
            et_next = {et_reg[15:8], byte_in};
            if ((et_next == TYPE_QTAG || et_next == TYPE_ADTAG) &&
                (((off8 - 8'd14) >> 2) < 8'(MAX_VLAN_TAGS))) begin
                off_next = off_reg + 5'd4;
            end
        end else if (p >= off8) begin
            if (p == off8) begin
                ver_next = byte_in[7:4];
                ihl_next = byte_in[3:0];
            end
            if (et_reg == TYPE_IPV4 && p >= off8 + 8'd12 && p <= off8 + 8'd15) begin
                slo_next = {32'h0, slo_reg[23:0], byte_in};
            end else if (et_reg == TYPE_IPV6 && p >= off8 + 8'd8 &&
                         p <= off8 + 8'd23) begin
                shi_next = {shi_reg[55:0], slo_reg[63:56]};
                slo_next = {slo_reg[55:0], byte_in};
            end
        end

        len  = {1'b0, cnt_next};
        offn = {3'b0, off_next};
        info.key_hi     = shi_next;
        info.key_lo     = slo_next;
        info.is_v6      = 1'b0;
        info.needs_scan = 1'b0;
        info.reason     = RSN_OTHER;
        if (len < offn) begin
            info.reason = RSN_MALF;
        end else if (et_next == TYPE_IPV4) begin
            if (len < offn + 8'd20 || ver_next != 4'd4 ||
                len < offn + {2'b0, ihl_next, 2'b0}) begin
                info.reason = RSN_MALF;
            end else begin
                info.needs_scan = 1'b1;
            end
        end else if (et_next == TYPE_IPV6) begin
            if (len < offn + 8'd40 || ver_next != 4'd6) begin
                info.reason = RSN_MALF;
            end else begin
                info.needs_scan = 1'b1;
                info.is_v6      = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || (byte_en && byte_last)) begin
            cnt_reg <= '0;
            et_reg  <= '0;
            off_reg <= 5'd14;
            ver_reg <= '0;
            ihl_reg <= '0;
            shi_reg <= '0;
            slo_reg <= '0;
        end else if (byte_en) begin
            cnt_reg <= cnt_next;
            et_reg  <= et_next;
            off_reg <= off_next;
            ver_reg <= ver_next;
            ihl_reg <= ihl_next;
            shi_reg <= shi_next;
            slo_reg <= slo_next;
        end
    end
endmodule
`default_nettype wire

>>> design/ip_source_allow_deny_filter_core.sv
// Top level of the IP source allow/deny filter: stream ports, APB register,
// rule memories and the per-frame table scan. Depends on ipsf_pkg, ipsf_parser.
//
// Channel   Dir  Signals                      Beat
// s_        in   tvalid tready tdata tuser tlast  frame byte or rule write
// m_        out  tvalid tready tdata             one verdict per frame
// apb       in   psel penable pwrite paddr pwdata  allow enforcement register
//
// The last byte of a well-formed IP frame starts a scan of both rule memories,
// one entry a cycle through each memory's single read port, and the verdict
// is raised once the scan is through.
// Input is stalled during the scan and while a verdict waits on m_tready.
// Reset is synchronous and marks every rule slot invalid at once.
`default_nettype none
module ip_source_allow_deny_filter_core #(
    parameter int ALLOW_ENTRIES = ipsf_pkg::ALLOW_ENTRIES_DEF,
    parameter int DENY_ENTRIES  = ipsf_pkg::DENY_ENTRIES_DEF,
    parameter int MAX_VLAN_TAGS = ipsf_pkg::MAX_VLAN_TAGS_DEF
) (
    input  wire          aclk,
    input  wire          aresetn,
    input  wire          s_tvalid,
    output logic         s_tready,
    // packet_byte[7:0] entry_index[13:8] entry_valid[14] entry_is_v6[15]
    // prefix_len[23:16] addr_hi[87:24] addr_lo[151:88]
    input  wire  [151:0] s_tdata,
    // cmd[1:0]
    input  wire  [1:0]   s_tuser,
    input  wire          s_tlast,
    output logic         m_tvalid,
    input  wire          m_tready,
    // verdict[0] reason[3:1], zero above
    output logic [7:0]   m_tdata,
    input  wire          psel,
    input  wire          penable,
    input  wire          pwrite,
    input  wire  [2:0]   paddr,
    input  wire  [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);
    import ipsf_pkg::*;

    localparam int SCAN_N = (ALLOW_ENTRIES > DENY_ENTRIES) ? ALLOW_ENTRIES : DENY_ENTRIES;
    localparam int CW = (SCAN_N > 1) ? $clog2(SCAN_N) : 1;
    localparam int AW = (ALLOW_ENTRIES > 1) ? $clog2(ALLOW_ENTRIES) : 1;
    localparam int DW = (DENY_ENTRIES > 1) ? $clog2(DENY_ENTRIES) : 1;

    logic enforce_reg;
    assign pready = 1'b1;
    assign prdata = (paddr == 3'd0) ? {31'h0, enforce_reg} : 32'h0;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enforce_reg <= 1'b0;
        end else if (psel && penable && pwrite && pready && paddr == 3'd0) begin
            enforce_reg <= pwdata[0];
        end
    end

    state_t state_reg, state_next;
    logic   acc;
    cmd_t   cmd;
    logic [7:0]  pbyte, plen_in, plen_cap;
    logic [5:0]  eidx;
    logic        evalid, ev6;
    logic [63:0] ahi, alo;
    logic [12:0] eidx_w;

    assign s_tready = (state_reg == ST_IDLE) && !m_tvalid;
    assign acc      = s_tvalid && s_tready;
    assign cmd      = cmd_t'(s_tuser);
    assign pbyte    = s_tdata[7:0];
    assign eidx     = s_tdata[13:8];
    assign evalid   = s_tdata[14];
    assign ev6      = s_tdata[15];
    assign plen_in  = s_tdata[23:16];
    assign ahi      = (evalid && ev6) ? s_tdata[87:24] : 64'h0;
    assign alo      = !evalid ? 64'h0 : (ev6 ? s_tdata[151:88] : {32'h0, s_tdata[119:88]});
    assign eidx_w   = {7'h0, eidx};
    assign plen_cap = !evalid ? 8'd0 :
                      (ev6 ? ((plen_in > 8'd128) ? 8'd128 : plen_in)
                           : ((plen_in > 8'd32) ? 8'd32 : plen_in));

    frame_info_t info;
    ipsf_parser #(.MAX_VLAN_TAGS(MAX_VLAN_TAGS)) u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .byte_en   (acc && cmd == CMD_BYTE),
        .byte_in   (pbyte),
        .byte_last (s_tlast),
        .info      (info)
    );

    allow_word_t allow_mem [ALLOW_ENTRIES];
    deny_word_t  deny_mem  [DENY_ENTRIES];
    logic [ALLOW_ENTRIES-1:0] allow_vld_reg;
    logic [DENY_ENTRIES-1:0]  deny_vld_reg;
    allow_word_t allow_rd_reg;
    deny_word_t  deny_rd_reg;
    logic        allow_ok_reg, deny_ok_reg, rd_pend_reg;
    logic [CW-1:0] scan_cnt_reg;
    logic        a_in, d_in, a_we, d_we;

    assign a_we = acc && cmd == CMD_ALLOW && 32'(eidx) < ALLOW_ENTRIES;
    assign d_we = acc && cmd == CMD_DENY && 32'(eidx) < DENY_ENTRIES;
    assign a_in = 32'(scan_cnt_reg) < ALLOW_ENTRIES;
    assign d_in = 32'(scan_cnt_reg) < DENY_ENTRIES;

    always_ff @(posedge aclk) begin
        if (a_we) begin
            allow_mem[eidx_w[AW-1:0]] <= '{hi: ahi, lo: alo, prefix: plen_cap, v6: ev6};
        end
        if (d_we) begin
            deny_mem[eidx_w[DW-1:0]] <= '{hi: ahi, lo: alo, v6: ev6};
        end
        allow_rd_reg <= allow_mem[scan_cnt_reg[AW-1:0]];
        deny_rd_reg  <= deny_mem[scan_cnt_reg[DW-1:0]];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            allow_vld_reg <= '0;
            deny_vld_reg  <= '0;
        end else begin
            if (a_we) allow_vld_reg[eidx_w[AW-1:0]] <= evalid;
            if (d_we) deny_vld_reg[eidx_w[DW-1:0]]  <= evalid;
        end
    end

    logic        key_v6_reg;
    logic [63:0] key_hi_reg, key_lo_reg;
    logic [127:0] mask, diff;
    logic        allow_hit, deny_hit, ahit_reg, dhit_reg;

    always_comb begin
        for (int b = 0; b < 128; b++) begin
            if (allow_rd_reg.v6) begin
                mask[b] = 8'(127 - b) < allow_rd_reg.prefix;
            end else begin
                mask[b] = (b < 32) && (8'(31 - b) < allow_rd_reg.prefix);
            end
        end
        diff = {key_hi_reg ^ allow_rd_reg.hi, key_lo_reg ^ allow_rd_reg.lo};
        allow_hit = rd_pend_reg && allow_ok_reg && allow_rd_reg.v6 == key_v6_reg &&
                    (diff & mask) == 128'h0;
        deny_hit  = rd_pend_reg && deny_ok_reg && deny_rd_reg.v6 == key_v6_reg &&
                    deny_rd_reg.hi == key_hi_reg && deny_rd_reg.lo == key_lo_reg;
    end

    logic    out_valid_reg;
    reason_t out_reason_reg;
    logic    fa, fd;
    assign fa = ahit_reg | allow_hit;
    assign fd = dhit_reg | deny_hit;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'h0, out_reason_reg,
                       (out_reason_reg == RSN_NOTALLW || out_reason_reg == RSN_DENIED)};

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (acc && cmd == CMD_BYTE && s_tlast && info.needs_scan) begin
                state_next = ST_SCAN;
            end
            ST_SCAN: if (32'(scan_cnt_reg) == SCAN_N - 1) begin
                state_next = ST_TAIL;
            end
            ST_TAIL: state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            rd_pend_reg   <= 1'b0;
            scan_cnt_reg  <= '0;
            ahit_reg      <= 1'b0;
            dhit_reg      <= 1'b0;
        end else begin
            state_reg   <= state_next;
            rd_pend_reg <= (state_reg == ST_SCAN);
            if (out_valid_reg && m_tready) out_valid_reg <= 1'b0;
            if (state_reg == ST_IDLE) begin
                scan_cnt_reg <= '0;
                ahit_reg     <= 1'b0;
                dhit_reg     <= 1'b0;
                if (acc && cmd == CMD_BYTE && s_tlast && !info.needs_scan) begin
                    out_valid_reg <= 1'b1;
                end
            end else if (state_reg == ST_SCAN) begin
                scan_cnt_reg <= scan_cnt_reg + CW'(1);
                ahit_reg     <= fa;
                dhit_reg     <= fd;
            end else begin
                out_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        allow_ok_reg <= a_in && allow_vld_reg[scan_cnt_reg[AW-1:0]];
        deny_ok_reg  <= d_in && deny_vld_reg[scan_cnt_reg[DW-1:0]];
        if (acc && cmd == CMD_BYTE && s_tlast) begin
            key_v6_reg     <= info.is_v6;
            key_hi_reg     <= info.key_hi;
            key_lo_reg     <= info.key_lo;
            out_reason_reg <= info.reason;
        end else if (state_reg == ST_TAIL) begin
            out_reason_reg <= (enforce_reg && !fa) ? RSN_NOTALLW :
                              (fd ? RSN_DENIED : RSN_CLEAN);
        end
    end

`ifndef NO_ASSERTIONS
    a_tail_out: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_TAIL) |=> out_valid_reg)
        else $error("verdict not raised after scan");
    a_scan_pend: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_TAIL) |-> rd_pend_reg)
        else $error("final scan read missing");
    a_no_take: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_IDLE) |-> !s_tready)
        else $error("input taken during scan");
`endif
endmodule
`default_nettype wire

>>> bench/ip_source_allow_deny_filter_core_tb.sv
// Self-checking bench for ip_source_allow_deny_filter_core: random Ethernet frames and
// rule writes on the input stream, verdicts checked against an in-bench predictor.
// Depends on ipsf_pkg and the filter core; nothing else.
`timescale 1ns / 100ps
module ip_source_allow_deny_filter_core_tb;
    import ipsf_pkg::*;

    typedef struct {
        cmd_t        cmd;
        logic [7:0]  pbyte;
        logic        last;
        logic [5:0]  idx;
        logic        valid;
        logic        v6;
        logic [7:0]  plen;
        logic [63:0] ahi;
        logic [63:0] alo;
    } beat_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    wire          s_tready;
    logic [151:0] s_tdata = '0;
    logic [1:0]   s_tuser = '0;
    logic         s_tlast = 1'b0;
    wire          m_tvalid;
    logic         m_tready = 1'b0;
    wire  [7:0]   m_tdata;
    logic         psel = 1'b0;
    logic         penable = 1'b0;
    logic         pwrite = 1'b0;
    logic [2:0]   paddr = '0;
    logic [31:0]  pwdata = '0;
    wire  [31:0]  prdata;
    wire          pready;

    ip_source_allow_deny_filter_core u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .s_tuser(s_tuser), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    beat_t       pending_beats[$];
    logic [7:0]  expected_verdicts[$];
    int          mismatches = 0;
    bit          quiet = 1'b0;
    int          hold_requests = 0;
    int          idle_cycles = 0;

    // Predictor state.
    bit          enforce = 1'b0;
    int          byte_cnt;
    logic [15:0] etype;
    int          hdr_off;
    logic [3:0]  ipver;
    logic [3:0]  ihl;
    logic [127:0] src;
    logic [127:0] allow_addr[64];
    int          allow_len[64];
    logic [1:0]  allow_fl[64];
    logic [127:0] deny_addr[64];
    logic [1:0]  deny_fl[64];
    logic [31:0]  pool4[$];
    logic [127:0] pool6[$];

    task automatic clear_frame();
        byte_cnt = 0;
        etype = '0;
        hdr_off = 14;
        ipver = '0;
        ihl = '0;
        src = '0;
    endtask

    function automatic bit source_allowed(bit v6);
        logic [127:0] m;
        for (int i = 0; i < 64; i++) begin
            if (allow_fl[i][0] && allow_fl[i][1] == v6) begin
                if (v6)
                    m = (allow_len[i] == 0) ? '0 : ~128'h0 << (128 - allow_len[i]);
                else
                    m = (allow_len[i] == 0) ? '0 : {96'h0, ~32'h0 << (32 - allow_len[i])};
                if (((src ^ allow_addr[i]) & m) == '0) return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    function automatic bit source_denied(bit v6);
        for (int i = 0; i < 64; i++)
            if (deny_fl[i][0] && deny_fl[i][1] == v6 && deny_addr[i] == src) return 1'b1;
        return 1'b0;
    endfunction

    function automatic reason_t frame_reason();
        bit v6;
        if (byte_cnt < hdr_off) return RSN_MALF;
        if (etype == TYPE_IPV4) begin
            if (byte_cnt < hdr_off + 20 || ipver != 4) return RSN_MALF;
            if (byte_cnt < hdr_off + 4 * ihl) return RSN_MALF;
            v6 = 1'b0;
        end else if (etype == TYPE_IPV6) begin
            if (byte_cnt < hdr_off + 40 || ipver != 6) return RSN_MALF;
            v6 = 1'b1;
        end else begin
            return RSN_OTHER;
        end
        if (enforce && !source_allowed(v6)) return RSN_NOTALLW;
        if (source_denied(v6)) return RSN_DENIED;
        return RSN_CLEAN;
    endfunction

    task automatic predict_filter(input beat_t b);
        int p;
        reason_t r;
        logic [127:0] a;
        a = b.v6 ? {b.ahi, b.alo} : {96'h0, b.alo[31:0]};
        case (b.cmd)
            CMD_BYTE: begin
                p = byte_cnt;
                byte_cnt = (p < int'(COUNT_MAX)) ? p + 1 : int'(COUNT_MAX);
                if (p == hdr_off - 2) begin
                    etype = {b.pbyte, 8'h00};
                end else if (p == hdr_off - 1) begin
                    etype[7:0] = b.pbyte;
                    if ((etype == TYPE_QTAG || etype == TYPE_ADTAG)
                            && (hdr_off - 14) / 4 < MAX_VLAN_TAGS_DEF)
                        hdr_off = hdr_off + 4;
                end else if (p >= hdr_off) begin
                    if (p == hdr_off) begin
                        ipver = b.pbyte[7:4];
                        ihl = b.pbyte[3:0];
                    end
                    if (etype == TYPE_IPV4 && p >= hdr_off + 12 && p <= hdr_off + 15)
                        src = {96'h0, src[23:0], b.pbyte};
                    else if (etype == TYPE_IPV6 && p >= hdr_off + 8 && p <= hdr_off + 23)
                        src = {src[119:0], b.pbyte};
                end
                if (b.last) begin
                    r = frame_reason();
                    expected_verdicts.push_back({4'h0, r,
                        (r == RSN_NOTALLW || r == RSN_DENIED) ? 1'b1 : 1'b0});
                    clear_frame();
                end
            end
            CMD_ALLOW: begin
                allow_addr[b.idx] = b.valid ? a : '0;
                allow_len[b.idx] = !b.valid ? 0 :
                    (b.plen > (b.v6 ? 128 : 32)) ? (b.v6 ? 128 : 32) : b.plen;
                allow_fl[b.idx] = b.valid ? {b.v6, 1'b1} : 2'b00;
            end
            CMD_DENY: begin
                deny_addr[b.idx] = b.valid ? a : '0;
                deny_fl[b.idx] = b.valid ? {b.v6, 1'b1} : 2'b00;
            end
            default: ;
        endcase
    endtask

    // Input driver.
    int s_gap = 0;
    always @(posedge aclk) begin
        beat_t nb;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                nb.cmd = cmd_t'(s_tuser);
                {nb.alo, nb.ahi, nb.plen, nb.v6, nb.valid, nb.idx, nb.pbyte} = s_tdata;
                nb.last = s_tlast;
                predict_filter(nb);
            end
            if (!(s_tvalid && !s_tready)) begin
                if (s_gap > 0) begin
                    s_gap--;
                    s_tvalid <= 1'b0;
                end else if (pending_beats.size() > 0) begin
                    nb = pending_beats.pop_front();
                    s_tdata <= {nb.alo, nb.ahi, nb.plen, nb.v6, nb.valid, nb.idx, nb.pbyte};
                    s_tuser <= nb.cmd;
                    s_tlast <= nb.last;
                    s_tvalid <= 1'b1;
                    if (!quiet && $urandom_range(0, 19) == 0) s_gap = $urandom_range(1, 10);
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Verdict monitor, receiver stalls and watchdog.
    int m_gap = 0;
    int hold_left = 0;
    int holds_taken = 0;
    always @(posedge aclk) begin
        logic [7:0] want;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (expected_verdicts.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected verdict beat: got %h", m_tdata);
                end else begin
                    want = expected_verdicts.pop_front();
                    if (m_tdata[0] !== want[0] || m_tdata[3:1] !== want[3:1]
                            || m_tdata[7:4] !== want[7:4]) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("verdict mismatch: expected verdict %0d reason %0d, got %h",
                                     want[0], want[3:1], m_tdata);
                    end
                end
            end
            if (holds_taken < hold_requests) begin
                holds_taken++;
                hold_left = 400;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (m_gap > 0) begin
                m_gap--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                if (!quiet && $urandom_range(0, 7) == 0) m_gap = $urandom_range(1, 10);
            end
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel)
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= 5000) begin
                $display("ip_source_allow_deny_filter_core_tb: done, errors");
                $finish;
            end
        end
    end

    task automatic push_beat(input cmd_t c, input logic [7:0] pb, input bit last,
                             input logic [5:0] idx, input bit valid, input bit v6,
                             input logic [7:0] plen, input logic [127:0] a);
        beat_t b;
        b.cmd = c; b.pbyte = pb; b.last = last; b.idx = idx; b.valid = valid;
        b.v6 = v6; b.plen = plen; b.ahi = a[127:64]; b.alo = a[63:0];
        pending_beats.push_back(b);
    endtask

    function automatic logic [127:0] rand128();
        return {$urandom, $urandom, $urandom, $urandom};
    endfunction

    task automatic push_rule(input bit is_deny);
        bit v6;
        logic [127:0] a;
        logic [7:0] plen;
        v6 = 1'($urandom_range(0, 1));
        a = rand128();
        if (v6) pool6.push_back(a); else pool4.push_back(a[31:0]);
        case ($urandom_range(0, 3))
            0: plen = 8'($urandom_range(0, 255));
            1: plen = v6 ? 8'd128 : 8'd32;
            default: plen = v6 ? 8'($urandom_range(0, 128)) : 8'($urandom_range(0, 32));
        endcase
        push_beat(is_deny ? CMD_DENY : CMD_ALLOW, 8'($urandom), 1'($urandom),
                  6'($urandom_range(0, 63)), $urandom_range(0, 9) != 0, v6, plen, a);
    endtask

    // Frame types: 0 IPv4, 1 IPv6, 2 other ethertype, 3 random ethertype.
    task automatic push_frame(input int kind, input int tags, input bit cut);
        logic [7:0] fb[$];
        logic [15:0] et;
        logic [127:0] s;
        int hlen, len;
        for (int i = 0; i < 12; i++) fb.push_back(8'($urandom));
        for (int t = 0; t < tags; t++) begin
            et = $urandom_range(0, 1) ? TYPE_QTAG : TYPE_ADTAG;
            fb.push_back(et[15:8]); fb.push_back(et[7:0]);
            fb.push_back(8'($urandom)); fb.push_back(8'($urandom));
        end
        et = kind == 0 ? TYPE_IPV4 : kind == 1 ? TYPE_IPV6 : kind == 2 ? 16'h0806
                                                                      : 16'($urandom);
        fb.push_back(et[15:8]); fb.push_back(et[7:0]);
        if (kind <= 1) begin
            if (kind == 0) s = (pool4.size() > 0 && $urandom_range(0, 2) != 0)
                ? {96'h0, pool4[$urandom_range(0, pool4.size() - 1)]} : 128'($urandom);
            else s = (pool6.size() > 0 && $urandom_range(0, 2) != 0)
                ? pool6[$urandom_range(0, pool6.size() - 1)] : rand128();
            if ($urandom_range(0, 1)) s ^= rand128() >> $urandom_range(0, 128);
            hlen = kind == 0 ? 20 : 40;
            for (int i = 0; i < hlen; i++) fb.push_back(8'($urandom));
            fb[12 + 4 * tags + 2] = {($urandom_range(0, 7) != 0) ? (kind == 0 ? 4'h4 : 4'h6)
                                     : 4'($urandom), 4'($urandom)};
            if (kind == 0 && $urandom_range(0, 3) != 0) fb[12 + 4 * tags + 2][3:0] = 4'h5;
            for (int i = 0; i < (kind == 0 ? 4 : 16); i++)
                fb[12 + 4 * tags + 2 + (kind == 0 ? 12 : 8) + i] =
                    s[8 * ((kind == 0 ? 4 : 16) - 1 - i) +: 8];
        end
        len = $urandom_range(0, 7) == 0 ? $urandom_range(0, 90) : $urandom_range(0, 12);
        for (int i = 0; i < len; i++) fb.push_back(8'($urandom));
        len = cut ? $urandom_range(1, fb.size()) : fb.size();
        for (int i = 0; i < len; i++) begin
            if ($urandom_range(0, 60) == 0)
                push_beat(cmd_t'($urandom_range(1, 3)), 8'($urandom), 1'($urandom),
                          6'($urandom), 1'b0, 1'($urandom), 8'($urandom), rand128());
            push_beat(CMD_BYTE, fb[i], i == len - 1, 6'($urandom), 1'($urandom),
                      1'($urandom), 8'($urandom), rand128());
        end
    endtask

    task automatic write_enforce(input bit value);
        wait (pending_beats.size() == 0 && !s_tvalid && expected_verdicts.size() == 0);
        repeat (80) @(posedge aclk);
        psel <= 1'b1; pwrite <= 1'b1; paddr <= '0;
        pwdata <= ({$urandom} << 1) | 32'(value);
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        enforce = value;
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    endtask

    initial begin
        int n;
        clear_frame();
        for (int i = 0; i < 64; i++) begin
            allow_addr[i] = '0; allow_len[i] = 0; allow_fl[i] = '0;
            deny_addr[i] = '0; deny_fl[i] = '0;
        end
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: prefix extremes, saturation, cleared slot, unused command, edge frames.
        pool4.push_back(32'hC0A80001);
        pool6.push_back(128'h20010DB8_00000000_00000000_00000001);
        push_beat(CMD_ALLOW, 8'h00, 1'b0, 6'd0, 1'b1, 1'b0, 8'd32, {~96'h0, 32'hC0A80001});
        push_beat(CMD_ALLOW, 8'hFF, 1'b1, 6'd63, 1'b1, 1'b1, 8'd255, pool6[0]);
        push_beat(CMD_ALLOW, 8'h00, 1'b0, 6'd5, 1'b1, 1'b0, 8'd200, ~128'h0);
        push_beat(CMD_ALLOW, 8'h00, 1'b0, 6'd5, 1'b0, 1'b1, 8'd0, ~128'h0);
        push_beat(CMD_DENY, 8'h00, 1'b0, 6'd63, 1'b1, 1'b1, 8'd0, pool6[0]);
        push_beat(CMD_DENY, 8'h00, 1'b0, 6'd0, 1'b1, 1'b0, 8'd0, {96'h0, 32'hC0A80001});
        push_beat(CMD_NONE, 8'hFF, 1'b1, 6'd63, 1'b1, 1'b1, 8'hFF, ~128'h0);
        push_beat(CMD_BYTE, 8'h00, 1'b1, 6'd0, 1'b0, 1'b0, 8'd0, '0);
        push_frame(0, 0, 1'b0);
        push_frame(1, 2, 1'b0);
        push_frame(0, 3, 1'b0);
        write_enforce(1'b1);
        push_beat(CMD_ALLOW, 8'h00, 1'b0, 6'd1, 1'b1, 1'b1, 8'd0, '0);
        push_frame(1, 1, 1'b0);
        push_frame(0, 0, 1'b0);

        for (int phase = 0; phase < 4; phase++) begin
            write_enforce(1'(phase % 2));
            if (phase == 3) quiet = 1'b1;
            n = 0;
            while (n < 390) begin
                if ($urandom_range(0, 3) == 0) begin
                    push_rule(1'($urandom_range(0, 1)));
                    n++;
                end else begin
                    push_frame($urandom_range(0, 9) < 4 ? 0 : $urandom_range(0, 9) < 7 ? 1
                               : $urandom_range(2, 3),
                               $urandom_range(0, 4) < 3 ? 0 : $urandom_range(1, 3),
                               $urandom_range(0, 6) == 0);
                    n += 50;
                end
                if (phase == 1 && n >= 200 && hold_requests == 0) hold_requests = 1;
                wait (pending_beats.size() < 200);
            end
        end

        wait (pending_beats.size() == 0 && !s_tvalid && expected_verdicts.size() == 0);
        repeat (100) @(posedge aclk);
        if (mismatches == 0 && expected_verdicts.size() == 0)
            $display("ip_source_allow_deny_filter_core_tb: done, clean");
        else
            $display("ip_source_allow_deny_filter_core_tb: done, errors");
        $finish;
    end
endmodule
